@@ rtl/core/multi_channel_timestamp_capture_defines.svh @@
// Assertion macros for the timestamp capture block.
`ifndef MULTI_CHANNEL_TIMESTAMP_CAPTURE_DEFINES_SVH
`define MULTI_CHANNEL_TIMESTAMP_CAPTURE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that prop holds at every clock edge outside reset.
`define MCTC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// Checks that cond never holds at a clock edge outside reset.
`define MCTC_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);
`else
`define MCTC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MCTC_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif

`endif

@@ rtl/core/mctc_pkg.sv @@
// Shared constants and types for the timestamp capture block.
package mctc_pkg;

  localparam int CHANNELS_DEF  = 6;
  localparam int TIME_BITS_DEF = 32;
  localparam int CHAN_BITS     = 3;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  // Store access strobes for one cycle.
  typedef struct packed {
    logic rd;
    logic wr;
  } mctc_ctl_t;

endpackage

@@ rtl/core/mctc_store.sv @@
// Per-channel stamp and interval memory with reset-clear valid bits.
module mctc_store
  import mctc_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mctc_ctl_t            ctl,
  input  logic [IDX_W-1:0]     addr,
  input  logic [TIME_BITS-1:0] wr_stamp,
  input  logic [TIME_BITS-1:0] wr_interval,
  output logic [TIME_BITS-1:0] rd_stamp,
  output logic [TIME_BITS-1:0] rd_interval
);

  logic [2*TIME_BITS-1:0] mem [CHANNELS];
  logic [2*TIME_BITS-1:0] q;
  logic [CHANNELS-1:0]    valid;
  logic                   hit;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= {wr_stamp, wr_interval};
    end
    if (ctl.rd) begin
      q <= mem[addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit   <= 1'b0;
    end else begin
      if (ctl.wr) begin
        valid[addr] <= 1'b1;
      end
      if (ctl.rd) begin
        hit <= valid[addr];
      end
    end
  end

  assign rd_stamp    = hit ? q[2*TIME_BITS-1:TIME_BITS] : '0;
  assign rd_interval = hit ? q[TIME_BITS-1:0] : '0;

endmodule

@@ rtl/core/multi_channel_timestamp_capture.sv @@
// Top level of the multi-channel timestamp capture unit.
//
//  port group  | dir | handshake          | beat contents
//  ------------+-----+--------------------+----------------------------------
//  input       | in  | in_valid/in_ready  | req_type, channel, now_time
//  output      | out | out_valid/out_ready| status, out_channel, stamp, interval
//
// A capture beat does a store read, then the interval subtract and write back;
// a capture on a channel out of range skips both. A read beat does the priority
// pick and store read, then the output load, which waits while the output
// register stays full. The single-port store sets the pace: one item in flight.
// Reset clears pending bits, store valid bits and the output register at once.
`include "multi_channel_timestamp_capture_defines.svh"

module multi_channel_timestamp_capture
  import mctc_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [CHAN_BITS-1:0] channel,
  input  logic [TIME_BITS-1:0] now_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic [CHAN_BITS-1:0] out_channel,
  output logic [TIME_BITS-1:0] stamp,
  output logic [TIME_BITS-1:0] interval
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // one spare bit so that CHANNELS itself fits in the compare
  localparam int CMP_W = ((IDX_W > CHAN_BITS) ? IDX_W : CHAN_BITS) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CAP  = 3'b010,
    S_RD   = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [CHANNELS-1:0]   pending;
  logic [IDX_W-1:0]      cur_idx;
  logic [TIME_BITS-1:0]  cap_time;
  logic                  rd_empty;

  logic                  in_fire;
  logic                  out_load;
  logic [CMP_W-1:0]      chan_ext;
  logic                  in_range;
  logic [IDX_W-1:0]      chan_idx;
  logic [IDX_W-1:0]      pick_idx;
  logic                  any_pending;

  mctc_ctl_t             ctl;
  logic [IDX_W-1:0]      st_addr;
  logic [TIME_BITS-1:0]  st_stamp;
  logic [TIME_BITS-1:0]  st_interval;
  logic [TIME_BITS-1:0]  wr_interval;

  function automatic logic [IDX_W-1:0] first_set(input logic [CHANNELS-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign chan_ext    = CMP_W'(channel);
  assign in_range    = chan_ext < CMP_W'(CHANNELS);
  assign chan_idx    = chan_ext[IDX_W-1:0];
  assign pick_idx    = first_set(pending);
  assign any_pending = |pending;
  assign out_load    = (state == S_RD) && (!out_valid || out_ready);
  assign wr_interval = cap_time - st_stamp;

  always_comb begin
    ctl     = '{rd: 1'b0, wr: 1'b0};
    st_addr = cur_idx;
    if (state == S_IDLE) begin
      st_addr = (req_type == REQ_READ) ? pick_idx : chan_idx;
      if (in_fire) begin
        ctl.rd = (req_type == REQ_READ) ? any_pending : in_range;
      end
    end else if (state == S_CAP) begin
      ctl.wr = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (req_type == REQ_READ) begin
            state_next = S_RD;
          end else if (in_range) begin
            state_next = S_CAP;
          end
        end
      end
      S_CAP: state_next = S_IDLE;
      S_RD: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (req_type == REQ_READ) begin
          if (any_pending) begin
            pending[pick_idx] <= 1'b0;
          end
        end else if (in_range) begin
          pending[chan_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cap_time <= now_time;
      rd_empty <= !any_pending;
      cur_idx  <= (req_type == REQ_READ) ? pick_idx : chan_idx;
    end
  end

  // output register: next read may be accepted while this beat waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= rd_empty ? ST_EMPTY : ST_OK;
      out_channel <= rd_empty ? '0 : CHAN_BITS'(cur_idx);
      stamp       <= rd_empty ? '0 : st_stamp;
      interval    <= rd_empty ? '0 : st_interval;
    end
  end

  mctc_store #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .addr        (st_addr),
    .wr_stamp    (cap_time),
    .wr_interval (wr_interval),
    .rd_stamp    (st_stamp),
    .rd_interval (st_interval)
  );

  `MCTC_ASSERT(a_read_clears_one, clk, rst, (in_fire && req_type == REQ_READ && any_pending) |=> ($countones(pending) + 1 == $countones($past(pending))), "read did not clear exactly one pending bit")
  `MCTC_ASSERT(a_cap_sets_pending, clk, rst, (in_fire && req_type == REQ_CAPTURE && in_range) |=> pending[$past(chan_idx)], "capture did not set pending bit")
  `MCTC_ASSERT(a_ok_channel_range, clk, rst, (out_valid && status == ST_OK) |-> (CMP_W'(out_channel) < CMP_W'(CHANNELS)), "returned channel out of range")
  `MCTC_ASSERT(a_empty_zero, clk, rst, (out_valid && status == ST_EMPTY) |-> (out_channel == '0 && stamp == '0 && interval == '0), "empty read with nonzero fields")
  `MCTC_NEVER(a_no_load_full, clk, rst, (state == S_RD) && $past(state == S_IDLE) && out_valid && !out_ready && out_load, "output overwritten while held")

endmodule

@@ tb/capture_read_checker.sv @@
// Monitor for the timestamp capture unit: predicts each read beat and checks the output.
`timescale 1ns / 100ps

module capture_read_checker
  import mctc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     req_type,
  input  logic [CHAN_BITS-1:0]     channel,
  input  logic [TIME_BITS_DEF-1:0] now_time,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     status,
  input  logic [CHAN_BITS-1:0]     out_channel,
  input  logic [TIME_BITS_DEF-1:0] stamp,
  input  logic [TIME_BITS_DEF-1:0] interval,
  output int                       fail_count,
  output int                       owed
);

  typedef logic [TIME_BITS_DEF-1:0] tick_t;

  typedef struct packed {
    logic                 st;
    logic [CHAN_BITS-1:0] chn;
    tick_t                ts;
    tick_t                iv;
  } meas_t;

  logic [CHANNELS_DEF-1:0] pend;
  tick_t                   last_ts [CHANNELS_DEF];
  tick_t                   last_iv [CHANNELS_DEF];
  meas_t                   owed_meas [$];

  // Applies one input beat to the shadow state; returns 1 when a read result is due.
  function automatic bit predict_beat(input logic rq, input logic [CHAN_BITS-1:0] ch,
                                      input tick_t t, output meas_t m);
    m    = '0;
    m.st = ST_EMPTY;
    if (rq == REQ_CAPTURE) begin
      // channels past the top one are dropped without a trace
      if (ch < CHANNELS_DEF) begin
        last_iv[ch] = t - last_ts[ch];
        last_ts[ch] = t;
        pend[ch]    = 1'b1;
      end
      return 1'b0;
    end
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      if (pend[i]) begin
        pend[i] = 1'b0;
        m.st    = ST_OK;
        m.chn   = CHAN_BITS'(i);
        m.ts    = last_ts[i];
        m.iv    = last_iv[i];
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    meas_t exp_m;
    meas_t new_m;
    if (rst) begin
      pend = '0;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        last_ts[i] = '0;
        last_iv[i] = '0;
      end
      owed_meas.delete();
      owed <= 0;
    end else begin
      // output side first: a beat leaving now always belongs to an earlier input
      if (out_valid && out_ready) begin
        if (owed_meas.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with none pending: st=%0d ch=%0d ts=%h iv=%h",
                     $realtime, status, out_channel, stamp, interval);
        end else begin
          exp_m = owed_meas.pop_front();
          if (status !== exp_m.st || out_channel !== exp_m.chn ||
              stamp !== exp_m.ts || interval !== exp_m.iv) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp st=%0d ch=%0d ts=%h iv=%h got st=%0d ch=%0d ts=%h iv=%h",
                       $realtime, exp_m.st, exp_m.chn, exp_m.ts, exp_m.iv,
                       status, out_channel, stamp, interval);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (predict_beat(req_type, channel, now_time, new_m))
          owed_meas.push_back(new_m);
      end
      owed <= owed_meas.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Top of the timestamp capture testbench: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
  import mctc_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_BEATS = 1625;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     req_type;
  logic [CHAN_BITS-1:0]     channel;
  logic [TIME_BITS_DEF-1:0] now_time;
  logic                     out_valid;
  logic                     out_ready;
  logic                     status;
  logic [CHAN_BITS-1:0]     out_channel;
  logic [TIME_BITS_DEF-1:0] stamp;
  logic [TIME_BITS_DEF-1:0] interval;

  int                       fail_count;
  int                       owed;
  int                       sent;
  int                       rx_beats;
  int                       idle_run;
  bit                       held;
  logic [TIME_BITS_DEF-1:0] clock_now;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multi_channel_timestamp_capture uut (
    .clk, .rst, .in_valid, .in_ready, .req_type, .channel, .now_time,
    .out_valid, .out_ready, .status, .out_channel, .stamp, .interval
  );

  capture_read_checker chk (
    .clk, .rst, .in_valid, .in_ready, .req_type, .channel, .now_time,
    .out_valid, .out_ready, .status, .out_channel, .stamp, .interval,
    .fail_count, .owed
  );

  task automatic send_beat(input logic rq, input int ch,
                           input logic [TIME_BITS_DEF-1:0] t);
    int gap;
    // every third stretch of 80 beats goes back to back
    gap = ((sent / 80) % 3 == 2) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    channel  <= CHAN_BITS'(ch);
    now_time <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // channel and time are don't-care on a read, so they get noise
  task automatic send_read();
    send_beat(REQ_READ, $urandom_range(0, 7), $urandom);
  endtask

  // Mostly a rising time base with some wraps, repeats and pure noise.
  function automatic logic [TIME_BITS_DEF-1:0] next_time();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6)
      clock_now += $urandom_range(1, 4000);
    else if (sel == 6)
      clock_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else if (sel < 9)
      return $urandom;
    return clock_now;
  endfunction

  initial begin
    int read_pct;
    int pick;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= REQ_CAPTURE;
    channel   <= '0;
    now_time  <= '0;
    clock_now  = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_read();                                   // empty read
    send_beat(REQ_CAPTURE, 0, 32'h0000_0000);      // first capture at time zero
    send_beat(REQ_CAPTURE, 5, 32'hFFFF_FFFF);      // first capture, top channel, max time
    send_beat(REQ_CAPTURE, 6, 32'h0000_3039);      // out of range, dropped
    send_beat(REQ_CAPTURE, 7, 32'hFFFF_FFFF);      // out of range, dropped
    send_read();
    send_beat(REQ_CAPTURE, 5, 32'h0000_0010);      // interval wraps
    send_beat(REQ_CAPTURE, 3, 32'h8000_0000);
    send_beat(REQ_CAPTURE, 3, 32'h8000_0005);      // overwrite before read
    send_read();
    send_read();
    send_read();                                   // empty again
    send_beat(REQ_CAPTURE, 1, 32'h5555_5555);
    send_beat(REQ_CAPTURE, 2, 32'hAAAA_AAAA);
    send_beat(REQ_CAPTURE, 4, 32'h0F0F_F0F0);
    send_beat(REQ_CAPTURE, 3, 32'h7FFF_FFFF);
    send_beat(REQ_CAPTURE, 0, 32'hFFFF_FFFF);
    repeat (6) send_read();                        // priority order, then empty

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       read_pct = 15;
          1:       read_pct = 45;
          default: read_pct = 75;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < read_pct)
        send_read();
      else if (pick < read_pct + 5)
        send_beat(REQ_CAPTURE, $urandom_range(CHANNELS_DEF, 7), $urandom);
      else
        send_beat(REQ_CAPTURE, $urandom_range(0, CHANNELS_DEF - 1), next_time());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (owed != 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && owed == 0)
      $display("** multi_channel_timestamp_capture: PASSED **");
    else
      $display("** multi_channel_timestamp_capture: FAILED **");
    $finish;
  end

  initial begin
    int wait_cyc;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_beats == 200 && !held) begin
        // long hold-off so the unit backs up and stalls its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        wait_cyc = ((rx_beats / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
        if (wait_cyc > 0) begin
          out_ready <= 1'b0;
          repeat (wait_cyc) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_beats++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run == IDLE_LIMIT) begin
      $display("** multi_channel_timestamp_capture: FAILED **");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule
